/* hdl/log_binned_size_histogram_unit_macros.svh */
// Assertion macros for the checker of the log-binned size histogram unit.
`ifndef LOG_BINNED_SIZE_HISTOGRAM_UNIT_MACROS_SVH
`define LOG_BINNED_SIZE_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define LBSH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define LBSH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/lbsh_pkg.sv */
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package lbsh_pkg;

   localparam int MAX_BINS    = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int PAIR_W      = 2 * COUNT_WIDTH;
   localparam int BIN_W       = $clog2(MAX_BINS);
   localparam int NBIN_W      = $clog2(MAX_BINS + 1);
   localparam int SIZE_W      = 64;
   localparam int BOUND_W     = 32;
   localparam int RATIO_W     = 5;
   localparam int NUMB_W      = 7;
   localparam int IDX_W       = 6;
   localparam int OUT_CNT_W   = 32;

   localparam int REQ_DATA_W  = 136;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 200;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_KIND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_BOUND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BINS    = 2'd3;

   localparam logic [BOUND_W-1:0] FIRST_BOUND_RST = 32'd1;
   localparam logic [RATIO_W-1:0] RATIO_RST       = 5'd2;
   localparam logic [NUMB_W-1:0]  NUM_BINS_RST    = 7'd33;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READ       = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic zero_bounds;
      logic rd;
      logic upd;
      logic miss;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic op;
      logic in_range;
      logic k_end;
      logic k_eq_idx;
      logic idx_zero;
      logic idx_in_use;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* hdl/log_binned_size_histogram_unit.sv */
// Top level of the log-binned size histogram: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Counts entry sizes in geometric bins and reports per-bin tallies on request.
// The req_ channel carries one item per transfer: an accumulate (tuser bit 0
// low) adds the entry to the first bin holding its size, a read (tuser bit 0
// high) returns one bin's counts and bounds. Every item yields exactly one
// transfer on the rsp_ channel, with tuser set when a bin was found or in use.
// Items are handled one at a time. The walk runs one bin per cycle, with one
// saturating bound multiply and one range compare per cycle; an item that
// settles on a bin then reads that bin's tallies and, for an accumulate,
// writes them back with one count raised, while a size matching no bin in
// use gives a miss result. The tallies live in a 64-entry RAM. A new item is
// taken in the cycle after the result is loaded into the output register, so
// a result waiting on a stalled receiver does not hold off the next item;
// only the following result waits. Reset clears the tallies at once through
// per-bin valid bits, loads the register defaults and empties the output
// register. csr_ writes are meant only for while the block is idle.
module log_binned_size_histogram_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Configuration writes.
   input  wire logic                                csr_we,
   input  wire logic [lbsh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lbsh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Item channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // apparent_size[63:0], actual_size[127:64], bin_index[133:128], zero pad.
   input  wire logic [lbsh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[0], is_dir[1].
   input  wire logic [lbsh_pkg::REQ_USER_W-1:0]     req_tuser,
   // Result channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // hit_bin[5:0], file total[37:6], directory total[69:38], bin_low[133:70],
   // bin_high[197:134], zero pad.
   output logic      [lbsh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // matched.
   output logic                                     rsp_tuser
);
   import lbsh_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // The controller decides what happens each cycle; the datapath holds every
   // register the decision acts on and reports back through the status bundle.
   lbsh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lbsh_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

/* hdl/lbsh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lbsh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/lbsh_ctrl.sv */
// Controller state machine: sequences the bin walk and the counter update.
`timescale 1ns / 1ps
`default_nettype none

module lbsh_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire lbsh_pkg::status_type sts,
   output lbsh_pkg::cmd_type         cmd
);
   import lbsh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_WALK,
      ST_RDREQ,
      ST_UPD,
      ST_MISS
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sts.op == OP_READ && !sts.idx_in_use) begin
               state_in = ST_MISS;
            end else if (sts.op == OP_READ && sts.idx_zero) begin
               cmd.zero_bounds = 1'b1;
               state_in        = ST_RDREQ;
            end else begin
               cmd.prep = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.op == OP_READ) begin
               if (sts.k_eq_idx) begin
                  state_in = ST_RDREQ;
               end else begin
                  cmd.step = 1'b1;
               end
            end else if (sts.k_end) begin
               state_in = ST_MISS;
            end else if (sts.in_range) begin
               state_in = ST_RDREQ;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_RDREQ: begin
            cmd.rd   = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (sts.out_free) begin
               cmd.upd  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MISS: begin
            if (sts.out_free) begin
               cmd.miss = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/lbsh_dp.sv */
// Datapath: registers, bound multiplier, range compare, tally RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

module lbsh_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [lbsh_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [lbsh_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic [lbsh_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire logic [lbsh_pkg::REQ_USER_W-1:0]        req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic      [lbsh_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                        rsp_tuser,
   input  wire lbsh_pkg::cmd_type                      cmd,
   output lbsh_pkg::status_type                        sts
);
   import lbsh_pkg::*;

   // Saturating multiply of a bound by the ratio.
   function automatic logic [SIZE_W-1:0] sat_mul(input logic [SIZE_W-1:0] a,
                                                 input logic [RATIO_W-1:0] r);
      logic [SIZE_W+RATIO_W-1:0] p;
      p = (SIZE_W + RATIO_W)'(a) * (SIZE_W + RATIO_W)'(r);
      return (|p[SIZE_W+RATIO_W-1:SIZE_W]) ? {SIZE_W{1'b1}} : p[SIZE_W-1:0];
   endfunction

   // Configuration registers.
   logic                size_kind_ff;
   logic [BOUND_W-1:0]  first_bound_ff;
   logic [RATIO_W-1:0]  ratio_ff;
   logic [NUMB_W-1:0]   num_bins_ff;

   // Item and walk registers.
   logic                op_ff;
   logic                is_dir_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [SIZE_W-1:0]   lo_ff;
   logic [SIZE_W-1:0]   hi_ff;
   logic [NBIN_W-1:0]   k_ff;

   logic [MAX_BINS-1:0] valid_ff;
   logic                valid_q_ff;

   logic                rsp_valid_ff;
   logic                rsp_matched_ff;
   logic [IDX_W-1:0]    rsp_hit_ff;
   logic [OUT_CNT_W-1:0] rsp_file_ff;
   logic [OUT_CNT_W-1:0] rsp_dir_ff;
   logic [SIZE_W-1:0]   rsp_low_ff;
   logic [SIZE_W-1:0]   rsp_high_ff;

   logic [NBIN_W-1:0]   n_eff;
   logic [RATIO_W-1:0]  r_eff;
   logic [SIZE_W-1:0]   mul_out;
   logic [BIN_W-1:0]    addr;
   logic [PAIR_W-1:0]   rd_pair;
   logic [COUNT_WIDTH-1:0] cur_file;
   logic [COUNT_WIDTH-1:0] cur_dir;
   logic [COUNT_WIDTH-1:0] new_file;
   logic [COUNT_WIDTH-1:0] new_dir;
   logic                ram_we;

   always_comb begin
      if (num_bins_ff == '0) begin
         n_eff = NBIN_W'(1);
      end else if (NBIN_W'(num_bins_ff) > NBIN_W'(MAX_BINS)) begin
         n_eff = NBIN_W'(MAX_BINS);
      end else begin
         n_eff = NBIN_W'(num_bins_ff);
      end
   end

   assign r_eff   = (ratio_ff < RATIO_W'(2)) ? RATIO_W'(2) : ratio_ff;
   // One shared multiplier: seeds the first upper bound, then advances the walk.
   assign mul_out = sat_mul(cmd.prep ? lo_ff : hi_ff, r_eff);
   assign addr    = k_ff[BIN_W-1:0];

   assign cur_file = valid_q_ff ? rd_pair[COUNT_WIDTH-1:0] : '0;
   assign cur_dir  = valid_q_ff ? rd_pair[PAIR_W-1:COUNT_WIDTH] : '0;

   always_comb begin
      new_file = cur_file;
      new_dir  = cur_dir;
      if (op_ff == OP_ACCUMULATE) begin
         if (is_dir_ff) begin
            if (cur_dir != {COUNT_WIDTH{1'b1}}) begin
               new_dir = cur_dir + COUNT_WIDTH'(1);
            end
         end else if (cur_file != {COUNT_WIDTH{1'b1}}) begin
            new_file = cur_file + COUNT_WIDTH'(1);
         end
      end
   end

   assign ram_we = cmd.upd && (op_ff == OP_ACCUMULATE);

   lbsh_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_BINS)
   ) u_tally (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data ({new_dir, new_file}),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (rd_pair)
   );

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_kind_ff   <= 1'b0;
         first_bound_ff <= FIRST_BOUND_RST;
         ratio_ff       <= RATIO_RST;
         num_bins_ff    <= NUM_BINS_RST;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_KIND:   size_kind_ff   <= csr_wdata[0];
               CSR_FIRST_BOUND: first_bound_ff <= csr_wdata[BOUND_W-1:0];
               CSR_RATIO:       ratio_ff       <= csr_wdata[RATIO_W-1:0];
               CSR_NUM_BINS:    num_bins_ff    <= csr_wdata[NUMB_W-1:0];
               default: ;
            endcase
         end
         if (ram_we) begin
            valid_ff[addr] <= 1'b1;
         end
         if (cmd.upd || cmd.miss) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_tuser[0];
         is_dir_ff <= req_tuser[1];
         idx_ff    <= req_tdata[133:128];
         size_ff   <= size_kind_ff ? req_tdata[127:64] : req_tdata[63:0];
         lo_ff     <= SIZE_W'(first_bound_ff);
         k_ff      <= NBIN_W'(1);
      end else if (cmd.zero_bounds) begin
         lo_ff <= '0;
         hi_ff <= '0;
         k_ff  <= '0;
      end else if (cmd.prep) begin
         hi_ff <= mul_out;
      end else if (cmd.step) begin
         lo_ff <= hi_ff;
         hi_ff <= mul_out;
         k_ff  <= k_ff + NBIN_W'(1);
      end
      if (cmd.rd) begin
         valid_q_ff <= valid_ff[addr];
      end
      if (cmd.upd) begin
         rsp_matched_ff <= 1'b1;
         rsp_hit_ff     <= IDX_W'(k_ff);
         rsp_file_ff    <= OUT_CNT_W'(new_file);
         rsp_dir_ff     <= OUT_CNT_W'(new_dir);
         rsp_low_ff     <= lo_ff;
         rsp_high_ff    <= hi_ff;
      end else if (cmd.miss) begin
         rsp_matched_ff <= 1'b0;
         rsp_hit_ff     <= (op_ff == OP_READ) ? idx_ff : '0;
         rsp_file_ff    <= '0;
         rsp_dir_ff     <= '0;
         rsp_low_ff     <= '0;
         rsp_high_ff    <= '0;
      end
   end

   assign sts.op         = op_ff;
   assign sts.in_range   = (size_ff >= lo_ff) && (size_ff < hi_ff);
   assign sts.k_end      = k_ff >= n_eff;
   assign sts.k_eq_idx   = k_ff == NBIN_W'(idx_ff);
   assign sts.idx_zero   = idx_ff == '0;
   assign sts.idx_in_use = NBIN_W'(idx_ff) < n_eff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_matched_ff;
   assign rsp_tdata  = {2'b00, rsp_high_ff, rsp_low_ff, rsp_dir_ff, rsp_file_ff, rsp_hit_ff};

endmodule

`default_nettype wire

/* hdl/lbsh_checker.sv */
// Port-level checker for the histogram unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "log_binned_size_histogram_unit_macros.svh"

module lbsh_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lbsh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);
   import lbsh_pkg::*;

   // A stalled result keeps its payload.
   `LBSH_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // One item at a time: no transfer in the cycle after one was taken.
   `LBSH_ASSERT_NXT(a_one_item, req_tvalid && req_tready, !req_tready, "item taken while another is in work")

   // A result never appears in the cycle right after its item was taken.
   `LBSH_ASSERT_NXT(a_no_early_rsp, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")

   // An unmatched result carries zero counts and bounds.
   `LBSH_ASSERT_IMP(a_miss_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[197:6] == '0, "miss with nonzero fields")

   // Bin zero is always the empty range.
   `LBSH_ASSERT_IMP(a_bin0_empty, rsp_tvalid && rsp_tuser && rsp_tdata[5:0] == '0, rsp_tdata[197:70] == '0, "bin zero has bounds")

endmodule

bind log_binned_size_histogram_unit lbsh_checker u_lbsh_checker (.*);

`default_nettype wire
